FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/ncs_pkg.sv
// types and constants shared by the flash command sequencer
`timescale 1ns / 1ps
package ncs_pkg;

    localparam int ADDR_BITS_DEFAULT = 21;
    localparam int DATA_W            = 16;
    localparam int PROTECT_W         = 21;
    localparam int APB_DATA_W        = 32;
    localparam int PADDR_W           = 3;
    localparam int STEP_W            = 3;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam int TOGGLE_BIT        = 6;

    localparam logic [0:0] REG_PROTECT_IDX = 1'b0;

    localparam logic [11:0] UNLOCK_ADDR_A = 12'h555;
    localparam logic [11:0] UNLOCK_ADDR_B = 12'h2AA;
    localparam logic [DATA_W-1:0] UNLOCK_DATA_A     = 16'h00AA;
    localparam logic [DATA_W-1:0] UNLOCK_DATA_B     = 16'h0055;
    localparam logic [DATA_W-1:0] CODE_PROGRAM      = 16'h00A0;
    localparam logic [DATA_W-1:0] CODE_ERASE_SETUP  = 16'h0080;
    localparam logic [DATA_W-1:0] CODE_ERASE_SECTOR = 16'h0030;
    localparam logic [DATA_W-1:0] CODE_RESET        = 16'h00F0;

    localparam logic [STEP_W-1:0] PROG_LAST_STEP  = 3'd4;
    localparam logic [STEP_W-1:0] ERASE_LAST_STEP = 3'd6;

    typedef enum logic [1:0] {
        CMD_PROGRAM = 2'd0,
        CMD_ERASE   = 2'd1,
        CMD_RESET   = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PROTECTED = 2'd1,
        ST_BUSY      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIRST = 2'd1,
        PH_POLL  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        JOB_SINGLE  = 2'd0,
        JOB_PROGRAM = 2'd1,
        JOB_ERASE   = 2'd2
    } t_job_op;

    typedef struct packed {
        t_job_op op;
        t_kind   kind;
        t_status status;
    } t_job_ctl;

endpackage

FILE: rtl/core/ncs_front.sv
// command classifier with the poll phase machine
`timescale 1ns / 1ps
module ncs_front
    import ncs_pkg::*;
#(
    parameter int WORD_ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_valid,
    output logic                      o_s_ready,
    input  t_cmd                      i_cmd,
    input  logic [WORD_ADDR_BITS-1:0] i_addr,
    input  logic [DATA_W-1:0]         i_data,
    input  logic [PROTECT_W-1:0]      i_protect,
    input  logic                      i_q_ready,
    output logic                      o_push,
    output t_job_ctl                  o_job,
    output logic [WORD_ADDR_BITS-1:0] o_job_addr,
    output logic [DATA_W-1:0]         o_job_data,
    output t_phase                    o_phase
);

    localparam int CmpW = (WORD_ADDR_BITS > PROTECT_W) ? WORD_ADDR_BITS : PROTECT_W;

    t_phase                    r_phase, n_phase;
    logic [WORD_ADDR_BITS-1:0] r_poll_addr, n_poll_addr;
    logic                      r_prev_toggle, n_prev_toggle;
    logic                      accept;
    logic                      toggle;
    logic                      busy;
    logic                      protected_hit;

    assign accept        = i_s_valid && i_q_ready;
    assign o_s_ready     = i_q_ready;
    assign o_push        = accept;
    assign o_phase       = r_phase;
    assign toggle        = i_data[TOGGLE_BIT];
    assign busy          = (r_phase == PH_FIRST) || (r_phase == PH_POLL);
    assign protected_hit = CmpW'(i_addr) < CmpW'(i_protect);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_poll_addr   <= '0;
            r_prev_toggle <= 1'b0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_poll_addr   <= n_poll_addr;
            r_prev_toggle <= n_prev_toggle;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_poll_addr   = r_poll_addr;
        n_prev_toggle = r_prev_toggle;
        o_job         = '{op: JOB_SINGLE, kind: KIND_DONE, status: ST_OK};
        o_job_addr    = '0;
        o_job_data    = '0;
        case (i_cmd)
            CMD_RESET: begin
                o_job.kind    = KIND_WRITE;
                o_job_data    = CODE_RESET;
                n_phase       = PH_IDLE;
                n_prev_toggle = 1'b0;
            end
            CMD_READ: begin
                case (r_phase)
                    PH_FIRST: begin
                        n_prev_toggle = toggle;
                        n_phase       = PH_POLL;
                        o_job.kind    = KIND_READ;
                        o_job_addr    = r_poll_addr;
                    end
                    PH_POLL: begin
                        if (toggle == r_prev_toggle) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_prev_toggle = toggle;
                            o_job.kind    = KIND_READ;
                            o_job_addr    = r_poll_addr;
                        end
                    end
                    default: begin
                        o_job.status = ST_BUSY;
                    end
                endcase
            end
            default: begin
                if (busy) begin
                    o_job.status = ST_BUSY;
                end else if (protected_hit) begin
                    o_job.status = ST_PROTECTED;
                end else begin
                    o_job.op      = (i_cmd == CMD_PROGRAM) ? JOB_PROGRAM : JOB_ERASE;
                    o_job.kind    = KIND_WRITE;
                    o_job_addr    = i_addr;
                    o_job_data    = i_data;
                    n_poll_addr   = i_addr;
                    n_prev_toggle = 1'b0;
                    n_phase       = PH_FIRST;
                end
            end
        endcase
    end

endmodule

FILE: rtl/core/ncs_queue.sv
// short job queue between classifier and bus sequencer
`timescale 1ns / 1ps
module ncs_queue
    import ncs_pkg::*;
#(
    parameter int WORD_ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  t_job_ctl                  i_job,
    input  logic [WORD_ADDR_BITS-1:0] i_job_addr,
    input  logic [DATA_W-1:0]         i_job_data,
    output logic                      o_ready,
    output logic                      o_valid,
    input  logic                      i_pop,
    output t_job_ctl                  o_job,
    output logic [WORD_ADDR_BITS-1:0] o_job_addr,
    output logic [DATA_W-1:0]         o_job_data
);

    t_job_ctl                  r_ctl  [QUEUE_DEPTH];
    logic [WORD_ADDR_BITS-1:0] r_addr [QUEUE_DEPTH];
    logic [DATA_W-1:0]         r_data [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]         r_count;
    logic                      do_push, do_pop;

    assign o_ready    = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid    = r_count != '0;
    assign do_push    = i_push && o_ready;
    assign do_pop     = i_pop && o_valid;
    assign o_job      = r_ctl[r_rd_ptr];
    assign o_job_addr = r_addr[r_rd_ptr];
    assign o_job_data = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ctl[r_wr_ptr]  <= i_job;
            r_addr[r_wr_ptr] <= i_job_addr;
            r_data[r_wr_ptr] <= i_job_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/ncs_back.sv
// bus sequencer expanding jobs into flash bus transfers
`timescale 1ns / 1ps
module ncs_back
    import ncs_pkg::*;
#(
    parameter int WORD_ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    output logic                      o_pop,
    input  t_job_ctl                  i_job,
    input  logic [WORD_ADDR_BITS-1:0] i_job_addr,
    input  logic [DATA_W-1:0]         i_job_data,
    output logic                      o_m_valid,
    input  logic                      i_m_ready,
    output t_kind                     o_kind,
    output logic [WORD_ADDR_BITS-1:0] o_addr,
    output logic [DATA_W-1:0]         o_data,
    output t_status                   o_status,
    output logic                      o_last
);

    localparam logic [WORD_ADDR_BITS-1:0] AddrA = WORD_ADDR_BITS'(UNLOCK_ADDR_A);
    localparam logic [WORD_ADDR_BITS-1:0] AddrB = WORD_ADDR_BITS'(UNLOCK_ADDR_B);

    logic [STEP_W-1:0]         r_step;
    logic                      r_valid;
    t_kind                     r_kind;
    logic [WORD_ADDR_BITS-1:0] r_addr;
    logic [DATA_W-1:0]         r_data;
    t_status                   r_status;
    logic                      r_last;

    t_kind                     res_kind;
    logic [WORD_ADDR_BITS-1:0] res_addr;
    logic [DATA_W-1:0]         res_data;
    t_status                   res_status;
    logic                      res_last;
    logic                      load;

    assign load      = i_q_valid && (!r_valid || i_m_ready);
    assign o_pop     = load && res_last;
    assign o_m_valid = r_valid;
    assign o_kind    = r_kind;
    assign o_addr    = r_addr;
    assign o_data    = r_data;
    assign o_status  = r_status;
    assign o_last    = r_last;

    always_comb begin
        res_kind   = KIND_WRITE;
        res_addr   = '0;
        res_data   = '0;
        res_status = ST_OK;
        res_last   = 1'b0;
        case (i_job.op)
            JOB_PROGRAM: begin
                case (r_step)
                    3'd0: begin
                        res_addr = AddrA;
                        res_data = UNLOCK_DATA_A;
                    end
                    3'd1: begin
                        res_addr = AddrB;
                        res_data = UNLOCK_DATA_B;
                    end
                    3'd2: begin
                        res_addr = AddrA;
                        res_data = CODE_PROGRAM;
                    end
                    3'd3: begin
                        res_addr = i_job_addr;
                        res_data = i_job_data;
                    end
                    default: begin
                        res_kind = KIND_READ;
                        res_addr = i_job_addr;
                        res_last = 1'b1;
                    end
                endcase
            end
            JOB_ERASE: begin
                case (r_step)
                    3'd0, 3'd3: begin
                        res_addr = AddrA;
                        res_data = UNLOCK_DATA_A;
                    end
                    3'd1, 3'd4: begin
                        res_addr = AddrB;
                        res_data = UNLOCK_DATA_B;
                    end
                    3'd2: begin
                        res_addr = AddrA;
                        res_data = CODE_ERASE_SETUP;
                    end
                    3'd5: begin
                        res_addr = i_job_addr;
                        res_data = CODE_ERASE_SECTOR;
                    end
                    default: begin
                        res_kind = KIND_READ;
                        res_addr = i_job_addr;
                        res_last = 1'b1;
                    end
                endcase
            end
            default: begin
                res_kind   = i_job.kind;
                res_addr   = i_job_addr;
                res_data   = i_job_data;
                res_status = i_job.status;
                res_last   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_step  <= res_last ? '0 : r_step + 1'b1;
        end else if (i_m_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= res_kind;
            r_addr   <= res_addr;
            r_data   <= res_data;
            r_status <= res_status;
            r_last   <= res_last;
        end
    end

endmodule

FILE: rtl/core/nor_flash_command_sequencer.sv
// Command sequencer for an AMD-style NOR flash with toggle-bit polling.
// Host commands and flash read returns enter on the s_ stream, tuser giving the command;
// bus writes, read requests and completion reports leave on the m_ stream, tlast marking
// the final transfer caused by each input. Commands are classified and the poll phase is
// updated as they are taken, then handed through a two-entry job queue to a sequencer that
// sends one bus transfer per cycle while m_tready is high: a program gives 5 transfers,
// an erase 7, any other command (reset, read return, refusal) 1, so single-transfer items
// flow at one per cycle. The protection limit register lies at APB byte address 0; it is
// to be written only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nor_flash_command_sequencer
    import ncs_pkg::*;
#(
    parameter  int WORD_ADDR_BITS = ADDR_BITS_DEFAULT,
    localparam int InTdataW       = ((WORD_ADDR_BITS + DATA_W + 7) / 8) * 8,
    localparam int OutTdataW      = ((WORD_ADDR_BITS + DATA_W + 2 + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [InTdataW-1:0]   s_tdata,   // word_address, data_word
    input  logic [1:0]            s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OutTdataW-1:0]  m_tdata,   // bus_address, bus_data, status
    output logic [1:0]            m_tuser,   // kind
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [PROTECT_W-1:0]      r_protect;
    logic                      q_ready, q_valid, push, pop;
    t_job_ctl                  f_job, q_job;
    logic [WORD_ADDR_BITS-1:0] f_job_addr, q_job_addr, b_addr;
    logic [DATA_W-1:0]         f_job_data, q_job_data, b_data;
    t_phase                    phase;
    t_kind                     b_kind;
    t_status                   b_status;
    logic                      reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2] == REG_PROTECT_IDX;
    assign prdata  = reg_sel ? APB_DATA_W'(r_protect) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protect <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_protect <= pwdata[PROTECT_W-1:0];
        end
    end

    ncs_front #(.WORD_ADDR_BITS(WORD_ADDR_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_tvalid),
        .o_s_ready  (s_tready),
        .i_cmd      (t_cmd'(s_tuser)),
        .i_addr     (s_tdata[WORD_ADDR_BITS-1:0]),
        .i_data     (s_tdata[WORD_ADDR_BITS+DATA_W-1:WORD_ADDR_BITS]),
        .i_protect  (r_protect),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_job      (f_job),
        .o_job_addr (f_job_addr),
        .o_job_data (f_job_data),
        .o_phase    (phase)
    );

    ncs_queue #(.WORD_ADDR_BITS(WORD_ADDR_BITS)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (f_job),
        .i_job_addr (f_job_addr),
        .i_job_data (f_job_data),
        .o_ready    (q_ready),
        .o_valid    (q_valid),
        .i_pop      (pop),
        .o_job      (q_job),
        .o_job_addr (q_job_addr),
        .o_job_data (q_job_data)
    );

    ncs_back #(.WORD_ADDR_BITS(WORD_ADDR_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_pop      (pop),
        .i_job      (q_job),
        .i_job_addr (q_job_addr),
        .i_job_data (q_job_data),
        .o_m_valid  (m_tvalid),
        .i_m_ready  (m_tready),
        .o_kind     (b_kind),
        .o_addr     (b_addr),
        .o_data     (b_data),
        .o_status   (b_status),
        .o_last     (m_tlast)
    );

    assign m_tuser = b_kind;
    assign m_tdata = OutTdataW'({b_status, b_data, b_addr});

    `ASSERT_IMPL(a_done_is_last, i_clk, i_rst_n,
        (m_tvalid && b_kind == KIND_DONE) |-> (m_tlast && b_addr == '0 && b_data == '0),
        "completion report not final or carries bus fields")
    `ASSERT_NEVER(a_bus_status_ok, i_clk, i_rst_n,
        m_tvalid && b_kind != KIND_DONE && b_status != ST_OK,
        "bus transfer carries a refusal status")
    `ASSERT_IMPL(a_reset_idles, i_clk, i_rst_n,
        (s_tvalid && s_tready && t_cmd'(s_tuser) == CMD_RESET) |=> (phase == PH_IDLE),
        "reset command did not return to idle")

endmodule

FILE: dv/tb.sv
// testbench for the nor flash command sequencer: directed and random runs against a predictor
`timescale 1ns / 1ps
module tb;
    import ncs_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          ITEMS_PER_SET  = 68;
    localparam int          N_SETTINGS     = 5;
    localparam logic [20:0] ADDR_MAX       = '1;

    typedef struct packed {
        t_kind       kind;
        logic [20:0] addr;
        logic [15:0] data;
        t_status     status;
        logic        last;
    } t_bus_op;

    typedef struct {
        bit          cfg;
        t_cmd        cmd;
        logic [20:0] addr;
        logic [15:0] data;
        bit          typed;
        t_bus_op     want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // word_address, data_word
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // bus_address, bus_data, status
    logic [1:0]  m_tuser;   // kind
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    t_phase      flash_phase;
    logic [20:0] poll_word;
    logic        toggle_seen;
    logic [20:0] protect_limit;
    t_bus_op     op_buf[7];
    int          op_cnt;

    t_bus_op     pending_bus_ops[$];
    t_dir_row    dir_rows[$];
    int          errors;
    int          items_sent;
    int          results_checked;
    int          settings_used;
    int          gap_pct;
    int          stall_pct;
    bit          hold_req;
    int          idle_cycles;

    nor_flash_command_sequencer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic string fmt_op(t_bus_op op);
        return $sformatf("kind=%0d addr=%h data=%h status=%0d last=%b",
                         op.kind, op.addr, op.data, op.status, op.last);
    endfunction

    function automatic void report_mismatch(string msg);
        errors++;
        if (errors <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void emit(t_kind kind, logic [20:0] addr, logic [15:0] data,
                                 t_status status);
        op_buf[op_cnt] = '{kind: kind, addr: addr, data: data, status: status, last: 1'b0};
        op_cnt++;
    endfunction

    function automatic void emit_unlock();
        emit(KIND_WRITE, 21'(UNLOCK_ADDR_A), UNLOCK_DATA_A, ST_OK);
        emit(KIND_WRITE, 21'(UNLOCK_ADDR_B), UNLOCK_DATA_B, ST_OK);
    endfunction

    function automatic void model_bus_cycles(t_cmd cmd, logic [20:0] addr, logic [15:0] data);
        logic toggle;
        logic busy;
        toggle = data[TOGGLE_BIT];
        busy   = (flash_phase == PH_FIRST) || (flash_phase == PH_POLL);
        op_cnt = 0;
        if (cmd == CMD_RESET) begin
            emit(KIND_WRITE, '0, CODE_RESET, ST_OK);
            flash_phase = PH_IDLE;
            toggle_seen = 1'b0;
        end else if (cmd == CMD_READ) begin
            if (flash_phase == PH_FIRST) begin
                toggle_seen = toggle;
                flash_phase = PH_POLL;
                emit(KIND_READ, poll_word, '0, ST_OK);
            end else if (flash_phase == PH_POLL) begin
                if (toggle == toggle_seen) begin
                    flash_phase = PH_IDLE;
                    emit(KIND_DONE, '0, '0, ST_OK);
                end else begin
                    toggle_seen = toggle;
                    emit(KIND_READ, poll_word, '0, ST_OK);
                end
            end else begin
                emit(KIND_DONE, '0, '0, ST_BUSY);
            end
        end else if (busy) begin
            emit(KIND_DONE, '0, '0, ST_BUSY);
        end else if (addr < protect_limit) begin
            emit(KIND_DONE, '0, '0, ST_PROTECTED);
        end else begin
            emit_unlock();
            if (cmd == CMD_PROGRAM) begin
                emit(KIND_WRITE, 21'(UNLOCK_ADDR_A), CODE_PROGRAM, ST_OK);
                emit(KIND_WRITE, addr, data, ST_OK);
            end else begin
                emit(KIND_WRITE, 21'(UNLOCK_ADDR_A), CODE_ERASE_SETUP, ST_OK);
                emit_unlock();
                emit(KIND_WRITE, addr, CODE_ERASE_SECTOR, ST_OK);
            end
            emit(KIND_READ, addr, '0, ST_OK);
            poll_word   = addr;
            toggle_seen = 1'b0;
            flash_phase = PH_FIRST;
        end
        op_buf[op_cnt-1].last = 1'b1;
    endfunction

    function automatic void add_row(t_cmd cmd, logic [20:0] addr, logic [15:0] data,
                                    bit typed = 1'b0, t_kind kind = KIND_WRITE,
                                    logic [20:0] bus_addr = '0, logic [15:0] bus_data = '0,
                                    t_status status = ST_OK);
        dir_rows.push_back('{cfg: 1'b0, cmd: cmd, addr: addr, data: data, typed: typed,
                             want: '{kind: kind, addr: bus_addr, data: bus_data,
                                    status: status, last: 1'b1}});
    endfunction

    function automatic logic [20:0] pick_addr();
        logic [20:0] a;
        case ($urandom_range(0, 3))
            0: a = 21'($urandom());
            1, 3: a = 21'($urandom_range(32'(ADDR_MAX), 32'(protect_limit)));
            default: begin
                case ($urandom_range(0, 3))
                    0: a = '0;
                    1: a = ADDR_MAX;
                    2: a = protect_limit;
                    default: a = protect_limit - 21'd1;
                endcase
            end
        endcase
        return a;
    endfunction

    task automatic send_item(t_cmd cmd, logic [20:0] addr, logic [15:0] data,
                             bit typed = 1'b0, t_bus_op want = '0);
        @(negedge i_clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {3'b000, data, addr};
        do @(posedge i_clk); while (!s_tready);
        model_bus_cycles(cmd, addr, data);
        if (typed) begin
            pending_bus_ops.push_back(want);
        end else begin
            for (int k = 0; k < op_cnt; k++) pending_bus_ops.push_back(op_buf[k]);
        end
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_bus_ops.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(bit write, logic [20:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {REG_PROTECT_IDX, 2'b00};
        pwdata  = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!write && prdata !== 32'(value)) begin
            report_mismatch($sformatf("protect limit readback expected %h actual %h",
                                      32'(value), prdata));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_protect(logic [20:0] value);
        drain();
        if (flash_phase != PH_IDLE) begin
            send_item(CMD_RESET, 21'($urandom()), 16'($urandom()));
            drain();
        end
        repeat (16) @(posedge i_clk);
        apb_access(1'b1, value);
        apb_access(1'b0, value);
        protect_limit = value;
        settings_used++;
    endtask

    task automatic run_random(int n_items);
        int          sent;
        int          flips;
        int          r;
        logic        t;
        logic [15:0] rd;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 70) begin
                send_item($urandom_range(0, 1) ? CMD_ERASE : CMD_PROGRAM, pick_addr(),
                          16'($urandom()));
                sent++;
                t     = 1'($urandom_range(0, 1));
                flips = $urandom_range(0, 5);
                while (flash_phase != PH_IDLE) begin
                    r = $urandom_range(0, 99);
                    if (r < 4) begin
                        send_item(CMD_RESET, 21'($urandom()), 16'($urandom()));
                    end else if (r < 10) begin
                        send_item($urandom_range(0, 1) ? CMD_ERASE : CMD_PROGRAM,
                                  pick_addr(), 16'($urandom()));
                    end else begin
                        if (flips > 0 && flash_phase == PH_POLL) begin
                            t = ~t;
                            flips--;
                        end
                        rd = 16'($urandom());
                        rd[TOGGLE_BIT] = t;
                        send_item(CMD_READ, 21'($urandom()), rd);
                    end
                    sent++;
                end
            end else begin
                send_item(t_cmd'(2'($urandom_range(0, 3))), pick_addr(), 16'($urandom()));
                sent++;
            end
        end
    endtask

    // receiver side: random stalls and one long hold-off
    initial begin
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_bus_op got;
        t_bus_op want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{kind: t_kind'(m_tuser), addr: m_tdata[20:0], data: m_tdata[36:21],
                    status: t_status'(m_tdata[38:37]), last: m_tlast};
            results_checked++;
            if (pending_bus_ops.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer %s", fmt_op(got)));
            end else begin
                want = pending_bus_ops.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("expected %s actual %s", fmt_op(want),
                                              fmt_op(got)));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("nor_flash_command_sequencer verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = CMD_PROGRAM;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        flash_phase     = PH_IDLE;
        poll_word       = '0;
        toggle_seen     = 1'b0;
        protect_limit   = '0;
        op_cnt          = 0;
        errors          = 0;
        items_sent      = 0;
        results_checked = 0;
        settings_used   = 0;
        gap_pct         = 20;
        stall_pct       = 20;
        hold_req        = 1'b0;
        idle_cycles     = 0;

        add_row(CMD_READ, 21'h000123, 16'h0040, 1, KIND_DONE, '0, '0, ST_BUSY);
        add_row(CMD_RESET, ADDR_MAX, 16'hFFFF, 1, KIND_WRITE, '0, CODE_RESET, ST_OK);
        add_row(CMD_PROGRAM, ADDR_MAX, 16'hFFFF);
        add_row(CMD_PROGRAM, 21'h000000, 16'h1234, 1, KIND_DONE, '0, '0, ST_BUSY);
        add_row(CMD_ERASE, 21'h0ABCDE, 16'h0000, 1, KIND_DONE, '0, '0, ST_BUSY);
        add_row(CMD_READ, 21'h000000, 16'h0040);
        add_row(CMD_READ, 21'h000000, 16'h0000);
        add_row(CMD_READ, ADDR_MAX, 16'h0000, 1, KIND_DONE, '0, '0, ST_OK);
        add_row(CMD_ERASE, 21'h000000, 16'hFFFF);
        add_row(CMD_READ, 21'h000000, 16'hFFBF);
        add_row(CMD_READ, 21'h000000, 16'hFFFF);
        add_row(CMD_RESET, 21'h000000, 16'h0000, 1, KIND_WRITE, '0, CODE_RESET, ST_OK);
        add_row(CMD_READ, 21'h000000, 16'hFFFF, 1, KIND_DONE, '0, '0, ST_BUSY);
        add_row(CMD_PROGRAM, 21'h000000, 16'h0000);
        add_row(CMD_READ, 21'h1FFFFF, 16'h0000);
        add_row(CMD_READ, 21'h1FFFFF, 16'h0000, 1, KIND_DONE, '0, '0, ST_OK);
        add_row(CMD_ERASE, 21'h155555, 16'hAAAA);
        add_row(CMD_RESET, 21'h155555, 16'h5555, 1, KIND_WRITE, '0, CODE_RESET, ST_OK);
        add_row(CMD_PROGRAM, 21'h0AAAAA, 16'h5555);
        add_row(CMD_READ, 21'h0AAAAA, 16'h0040);
        add_row(CMD_READ, 21'h0AAAAA, 16'h0040, 1, KIND_DONE, '0, '0, ST_OK);
        dir_rows.push_back('{cfg: 1'b1, cmd: CMD_PROGRAM, addr: 21'h100000, data: '0,
                             typed: 1'b0, want: '0});
        add_row(CMD_PROGRAM, 21'h0FFFFF, 16'hFFFF, 1, KIND_DONE, '0, '0, ST_PROTECTED);
        add_row(CMD_ERASE, 21'h000000, 16'h0000, 1, KIND_DONE, '0, '0, ST_PROTECTED);
        add_row(CMD_PROGRAM, 21'h100000, 16'h8001);

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg) begin
                set_protect(dir_rows[i].addr);
            end else begin
                send_item(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].data,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int p = 0; p < N_SETTINGS; p++) begin
            case (p)
                0: set_protect(21'h0C0000);
                1: set_protect(ADDR_MAX);
                2: set_protect(21'h000000);
                3: set_protect(21'($urandom()));
                default: set_protect(21'h000001);
            endcase
            case (p)
                0: begin gap_pct = 20; stall_pct = 25; end
                1: begin gap_pct = 35; stall_pct = 10; end
                2: begin gap_pct = 0;  stall_pct = 15; end
                3: begin gap_pct = 15; stall_pct = 0;  end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            // long receiver hold-off so the job queue fills and the input stalls
            if (p == 2) hold_req = 1'b1;
            run_random(ITEMS_PER_SET);
        end

        drain();
        repeat (32) @(posedge i_clk);
        $display("%0d commands and read returns sent, %0d bus transfers checked", items_sent,
                 results_checked);
        $display("%0d protection limit settings, %0d mismatches", settings_used, errors);
        if (errors == 0) begin
            $display("nor_flash_command_sequencer verification clean");
        end else begin
            $display("nor_flash_command_sequencer verification failed");
        end
        $finish;
    end

endmodule
